[design/mfhp_pkg.sv]
// Shared types and codes for the MQTT fixed header parser.
package mfhp_pkg;

  localparam int LEN_W = 28;
  localparam int MAX_LENGTH_BYTES_DEF = 4;

  localparam logic [1:0] PH_FIRST   = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [1:0] KIND_FIRST     = 2'd0;
  localparam logic [1:0] KIND_LENGTH    = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD   = 2'd2;
  localparam logic [1:0] KIND_MALFORMED = 2'd3;

  localparam logic [7:0] TYPE_MASK  = 8'hF0;
  localparam logic [7:0] FLAGS_MASK = 8'h0F;
  localparam logic [7:0] GROUP_MASK = 8'h7F;
  localparam logic [7:0] CONT_BIT   = 8'h80;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [1:0]       byte_kind;
    logic [3:0]       packet_type;
    logic [3:0]       packet_flags;
    logic [LEN_W-1:0] remaining_length;
    logic             header_complete;
    logic             packet_end;
  } result_t;

endpackage

[design/mqtt_fixed_header_parser.sv]
// Top level of the MQTT fixed header parser.
//
//   channel  handshake              payload
//   -------  ---------------------  ------------------------------------------
//   input    src_valid / src_ready  in_byte
//   result   res_valid / res_ready  data_byte, byte_kind, packet_type,
//                                   packet_flags, remaining_length,
//                                   header_complete, packet_end
//
// One beat in, one beat out; a beat can be taken every cycle unless the result stalls.
// A beat is held in the input register, then decoded into the result register.
// The header state advances when a beat moves from the input to the result register.
// A stalled result holds; the input register still takes one beat behind it.
// Synchronous reset clears both stage valids and the header state.
module mqtt_fixed_header_parser
  import mfhp_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_ready,
  input  logic [7:0]       in_byte,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [7:0]       data_byte,
  output logic [1:0]       byte_kind,
  output logic [3:0]       packet_type,
  output logic [3:0]       packet_flags,
  output logic [LEN_W-1:0] remaining_length,
  output logic             header_complete,
  output logic             packet_end
);

  logic       item_valid;
  logic [7:0] item_byte;
  logic       advance;
  result_t    item_result;
  result_t    res;

  mfhp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .in_byte    (in_byte),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .advance    (advance)
  );

  mfhp_decode #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item_byte (item_byte),
    .result    (item_result)
  );

  mfhp_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_result (item_result),
    .advance     (advance),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign data_byte        = res.data_byte;
  assign byte_kind        = res.byte_kind;
  assign packet_type      = res.packet_type;
  assign packet_flags     = res.packet_flags;
  assign remaining_length = res.remaining_length;
  assign header_complete  = res.header_complete;
  assign packet_end       = res.packet_end;

  a_rst_empty: assert property (@(posedge clk) rst |=> !res_valid && src_ready)
    else $error("pipeline not empty after reset");

  a_malformed_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && byte_kind == KIND_MALFORMED |-> !header_complete && !packet_end)
    else $error("malformed length beat marked complete or end");

  a_first_zero_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && byte_kind == KIND_FIRST |-> remaining_length == '0 && !packet_end)
    else $error("first header beat with nonzero length or end mark");

  a_hdr_is_length: assert property (@(posedge clk) disable iff (rst)
    res_valid && header_complete |-> byte_kind == KIND_LENGTH)
    else $error("header complete on a non-length beat");

endmodule

[design/mfhp_in_stage.sv]
// Input register for the incoming byte stream.
module mfhp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_ready,
  input  logic [7:0] in_byte,
  output logic       item_valid,
  output logic [7:0] item_byte,
  input  logic       advance
);

  logic       valid;
  logic [7:0] held_byte;

  assign src_ready  = !valid || advance;
  assign item_valid = valid;
  assign item_byte  = held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (src_ready) begin
      valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

[design/mfhp_decode.sv]
// Header state and per-byte decode logic.
module mfhp_decode
  import mfhp_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] item_byte,
  output result_t    result
);

  logic [1:0]       phase, phase_next;
  logic [3:0]       held_type, held_type_next;
  logic [3:0]       held_flags, held_flags_next;
  logic [LEN_W-1:0] length_accumulator, length_accumulator_next;
  logic [1:0]       length_byte_index, length_byte_index_next;
  logic [LEN_W-1:0] payload_left, payload_left_next;

  logic [LEN_W-1:0] group;
  logic [4:0]       shift;
  logic [2:0]       idx_plus;
  logic [1:0]       kind;
  logic             hdr_done;
  logic             pkt_end;

  always_comb begin
    shift    = 5'(length_byte_index) * 5'd7;
    group    = LEN_W'(item_byte & GROUP_MASK) << shift;
    idx_plus = {1'b0, length_byte_index} + 3'd1;

    phase_next              = phase;
    held_type_next          = held_type;
    held_flags_next         = held_flags;
    length_accumulator_next = length_accumulator;
    length_byte_index_next  = length_byte_index;
    payload_left_next       = payload_left;
    kind                    = KIND_FIRST;
    hdr_done                = 1'b0;
    pkt_end                 = 1'b0;

    case (phase)
      PH_LENGTH: begin
        length_accumulator_next = length_accumulator + group;
        kind = KIND_LENGTH;
        if ((item_byte & CONT_BIT) != 8'd0) begin
          if (32'(idx_plus) >= 32'(MAX_LENGTH_BYTES)) begin
            kind       = KIND_MALFORMED;
            phase_next = PH_FIRST;
          end else begin
            length_byte_index_next = idx_plus[1:0];
          end
        end else begin
          hdr_done = 1'b1;
          if (length_accumulator_next == '0) begin
            pkt_end    = 1'b1;
            phase_next = PH_FIRST;
          end else begin
            payload_left_next = length_accumulator_next;
            phase_next        = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        kind              = KIND_PAYLOAD;
        payload_left_next = payload_left - LEN_W'(1);
        if (payload_left_next == '0) begin
          pkt_end    = 1'b1;
          phase_next = PH_FIRST;
        end
      end
      default: begin
        held_type_next          = 4'((item_byte & TYPE_MASK) >> 4);
        held_flags_next         = 4'(item_byte & FLAGS_MASK);
        length_accumulator_next = '0;
        length_byte_index_next  = 2'd0;
        payload_left_next       = '0;
        phase_next              = PH_LENGTH;
      end
    endcase

    result.data_byte        = item_byte;
    result.byte_kind        = kind;
    result.packet_type      = held_type_next;
    result.packet_flags     = held_flags_next;
    result.remaining_length = length_accumulator_next;
    result.header_complete  = hdr_done;
    result.packet_end       = pkt_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_FIRST;
      held_type          <= 4'd0;
      held_flags         <= 4'd0;
      length_accumulator <= '0;
      length_byte_index  <= 2'd0;
      payload_left       <= '0;
    end else if (advance) begin
      phase              <= phase_next;
      held_type          <= held_type_next;
      held_flags         <= held_flags_next;
      length_accumulator <= length_accumulator_next;
      length_byte_index  <= length_byte_index_next;
      payload_left       <= payload_left_next;
    end
  end

endmodule

[design/mfhp_out_stage.sv]
// Result register toward the downstream consumer.
module mfhp_out_stage
  import mfhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  result_t item_result,
  output logic    advance,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  logic    valid;
  result_t held;

  assign advance   = item_valid && (!valid || res_ready);
  assign res_valid = valid;
  assign res       = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || res_ready) begin
      valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= item_result;
    end
  end

endmodule
